### hdl/sspt_pkg.sv
// Shared types, constants and helper functions for the shaft speed pulse timing block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package sspt_pkg;

  // Field widths
  localparam int unsigned CLK_W      = 27;
  localparam int unsigned ANG_W      = 6;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SPD_W      = 30;
  localparam int unsigned TMR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 27;

  // Divider datapath
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned STEP_W = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [STEP_W-1:0]    step_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_CLOCK_HZ  = 2'd0;
  localparam cfg_idx_t CFG_ON_ANGLE  = 2'd1;
  localparam cfg_idx_t CFG_OFF_ANGLE = 2'd2;

  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 27'd84000000;
  localparam logic [TMR_W-1:0] TIMER_FULL   = 16'hFFFF;

  // Speed quotient is below 2^30; prescale quotient (count / 65535) is below 2^17
  localparam step_t SPEED_STEPS    = 5'd30;
  localparam step_t PRESCALE_STEPS = 5'd17;

  // Request into the shared divider
  typedef struct packed {
    logic             start;
    step_t            steps;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // Status out of the shared divider
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_sts_t;

  // angle * 65535 / 45 = angle * 1456 + angle / 3, saturated at 65535
  function automatic logic [TMR_W-1:0] angle_ticks(input logic [ANG_W-1:0] angle);
    logic [16:0] whole;
    logic [4:0]  third;
    logic [17:0] sum;
    whole = 17'(angle) * 17'd1456;
    third = 5'((14'(angle) * 14'd171) >> 9);
    sum   = 18'(whole) + 18'(third);
    return (sum > 18'(TIMER_FULL)) ? TIMER_FULL : sum[TMR_W-1:0];
  endfunction

endpackage

### hdl/sspt_in_if.sv
// Request channel into the block: one period count per request.
// Depends on sspt_pkg for the field width.
`timescale 1ns / 1ps

interface sspt_in_if;
  logic                            valid;
  logic                            ready;
  logic [sspt_pkg::CNT_W-1:0]      period_count;

  modport source (output valid, output period_count, input ready);
  modport sink   (input valid, input period_count, output ready);
endinterface

### hdl/sspt_out_if.sv
// Result channel out of the block: speed and one-pulse timer settings.
// Depends on sspt_pkg for the field widths.
`timescale 1ns / 1ps

interface sspt_out_if;
  logic                            valid;
  logic                            ready;
  logic [sspt_pkg::SPD_W-1:0]      speed_rpm;
  logic [sspt_pkg::TMR_W-1:0]      prescale_value;
  logic [sspt_pkg::TMR_W-1:0]      pulse_width;
  logic [sspt_pkg::TMR_W-1:0]      pulse_period;

  modport source (output valid, output speed_rpm, output prescale_value,
                  output pulse_width, output pulse_period, input ready);
  modport sink   (input valid, input speed_rpm, input prescale_value,
                  input pulse_width, input pulse_period, output ready);
endinterface

### hdl/shaft_speed_pulse_timing.sv
// Shaft speed from encoder period counts, with one-pulse timer settings.
// A new request is taken only once the previous one has left the emit state and the block is idle.
// The shared divider works out the speed first, in 30 steps, then the prescaler, in 17.
// A pending result waits in an output register while the next request is worked on.
// Reset (rst_n, synchronous, active low) restores the register defaults and clears the kept speed.
`timescale 1ns / 1ps

module shaft_speed_pulse_timing (
  input  logic                                clk,
  input  logic                                rst_n,
  sspt_in_if.sink                             in_chan,
  sspt_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  sspt_pkg::cfg_idx_t                  cfg_index,
  input  logic [sspt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SPEED = 4'b0010,
    ST_PRESC = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [sspt_pkg::CLK_W-1:0]      clk_hz_r;
  logic [sspt_pkg::ANG_W-1:0]      on_ang_r;
  logic [sspt_pkg::ANG_W-1:0]      off_ang_r;
  logic [sspt_pkg::CNT_W-1:0]      cnt_r;
  logic [sspt_pkg::SPD_W-1:0]      spd_r;
  logic [sspt_pkg::TMR_W-1:0]      psc_r;
  logic [sspt_pkg::SPD_W-1:0]      last_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [sspt_pkg::SPD_W-1:0]      out_spd_r;
  logic [sspt_pkg::TMR_W-1:0]      out_psc_r;
  logic [sspt_pkg::TMR_W-1:0]      out_pw_r;
  logic [sspt_pkg::TMR_W-1:0]      out_pp_r;

  sspt_pkg::div_req_t              div_req;
  sspt_pkg::div_sts_t              div_sts;

  logic                            accept;
  logic [30:0]                     num;
  logic [sspt_pkg::CNT_W-1:0]      dvs_sel;
  logic                            changed;
  logic                            out_free;
  logic                            emit_load;
  logic                            emit_leave;

  sspt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  // Take a request only when the sequencer is idle
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // clock * 15 by shift and subtract; the factor 2 of the divisor folds into a halving
  always_comb begin
    num     = ({4'b0, clk_hz_r} << 4) - {4'b0, clk_hz_r};
    dvs_sel = (in_chan.period_count == '0) ? 32'd1 : in_chan.period_count;
  end

  // Drive the shared divider: speed first, prescale second
  always_comb begin
    div_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        div_req.start    = accept;
        div_req.steps    = sspt_pkg::SPEED_STEPS;
        div_req.dividend = {2'b0, num[30:1]};
        div_req.divisor  = dvs_sel;
      end
      ST_SPEED: begin
        div_req.start    = div_sts.done;
        div_req.steps    = sspt_pkg::PRESCALE_STEPS;
        div_req.dividend = cnt_r;
        div_req.divisor  = {16'b0, sspt_pkg::TIMER_FULL};
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Emit only on a speed change, and only when the output register is free
  always_comb begin
    changed    = (spd_r != last_r);
    out_free   = !out_valid_r || out_chan.ready;
    emit_load  = (state_r == ST_EMIT) && changed && out_free;
    emit_leave = (state_r == ST_EMIT) && (!changed || out_free);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SPEED;
      ST_SPEED: if (div_sts.done) state_nxt = ST_PRESC;
      ST_PRESC: if (div_sts.done) state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_leave) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = emit_load || (out_valid_r && !out_chan.ready);

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      clk_hz_r    <= sspt_pkg::CLK_HZ_RESET;
      on_ang_r    <= '0;
      off_ang_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit_leave) begin
        last_r <= spd_r;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          sspt_pkg::CFG_CLOCK_HZ:  clk_hz_r  <= cfg_wdata[sspt_pkg::CLK_W-1:0];
          sspt_pkg::CFG_ON_ANGLE:  on_ang_r  <= cfg_wdata[sspt_pkg::ANG_W-1:0];
          sspt_pkg::CFG_OFF_ANGLE: off_ang_r <= cfg_wdata[sspt_pkg::ANG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: hold the count, capture quotients, load the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r <= in_chan.period_count;
    end
    if ((state_r == ST_SPEED) && div_sts.done) begin
      spd_r <= div_sts.quotient[sspt_pkg::SPD_W-1:0];
    end
    if ((state_r == ST_PRESC) && div_sts.done) begin
      psc_r <= div_sts.quotient[sspt_pkg::TMR_W-1:0] - 16'd1;
    end
    if (emit_load) begin
      out_spd_r <= spd_r;
      out_psc_r <= psc_r;
      out_pw_r  <= sspt_pkg::angle_ticks(on_ang_r);
      out_pp_r  <= sspt_pkg::angle_ticks(off_ang_r);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.speed_rpm      = out_spd_r;
  assign out_chan.prescale_value = out_psc_r;
  assign out_chan.pulse_width    = out_pw_r;
  assign out_chan.pulse_period   = out_pp_r;

`ifndef NO_ASSERTIONS
  // The divider is never restarted mid-division
  assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_sts.busy)
    else $error("divider started while busy");
  // A new request is taken only with the divider at rest
  assert property (@(posedge clk) disable iff (!rst_n) in_chan.ready |-> !div_sts.busy)
    else $error("ready while divider busy");
  // An emitted result carries the speed that was just kept
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> (out_chan.valid && (out_chan.speed_rpm == last_r)))
    else $error("emitted speed differs from kept speed");
`endif

endmodule

### hdl/sspt_div.sv
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on sspt_pkg for the request and status structs.
`timescale 1ns / 1ps

module sspt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  sspt_pkg::div_req_t req,
  output sspt_pkg::div_sts_t sts
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  sspt_pkg::step_t              cnt_r, cnt_nxt;
  logic [sspt_pkg::DIV_W-1:0]   rem_r, rem_nxt;
  logic [sspt_pkg::DIV_W-1:0]   quo_r, quo_nxt;
  logic [sspt_pkg::DIV_W-1:0]   dvs_r, dvs_nxt;
  logic [sspt_pkg::DIV_W:0]     trial;
  logic [sspt_pkg::DIV_W:0]     diff;
  logic                         fits;

  // Shift one dividend bit into the partial remainder and try the subtract
  always_comb begin
    trial = {rem_r, quo_r[sspt_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Load on start, else advance one step while busy
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvs_nxt  = req.divisor;
      rem_nxt  = req.dividend >> req.steps;
      quo_nxt  = req.dividend << (sspt_pkg::DIV_W - int'(req.steps));
    end else if (busy_r) begin
      rem_nxt = fits ? diff[sspt_pkg::DIV_W-1:0] : trial[sspt_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[sspt_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

`ifndef NO_ASSERTIONS
  // Partial remainder stays below the divisor through every step
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> (rem_r < dvs_r))
    else $error("divider remainder reached the divisor");
  // Completion only after a running division, never while still running
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> (!busy_r && $past(busy_r)))
    else $error("divider done without a running division");
`endif

endmodule
